// ===== hdl/slist_pkg.sv =====
// Shared types, field widths and codes for the sequential list engine.
package slist_pkg;

  localparam int CAPACITY_DEF = 128;

  localparam int OP_W   = 3;
  localparam int POS_W  = 8;
  localparam int VAL_W  = 32;
  localparam int STAT_W = 2;
  localparam int IDX_W  = 7;
  localparam int CNT_W  = 8;

  typedef enum logic [OP_W-1:0] {
    OP_GET    = 3'd0,
    OP_LOCATE = 3'd1,
    OP_INSERT = 3'd2,
    OP_DELETE = 3'd3,
    OP_CLEAR  = 3'd4,
    OP_APPEND = 3'd5
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK         = 2'd0,
    ST_BAD_POS    = 2'd1,
    ST_FULL       = 2'd2,
    ST_MATCH_FAIL = 2'd3
  } status_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    load;
    logic    walk_init;
    logic    walk_step;
    logic    get_capture;
    logic    set_status;
    status_t status_code;
    logic    put;
    logic    count_dec;
    logic    count_clr;
    logic    result_load;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    op_t  op;
    logic get_ok;
    logic ins_ok;
    logic full;
    logic hit;
    logic walk_done;
    logic out_free;
  } dp_stat_t;

endpackage

// ===== hdl/slist_req_if.sv =====
// Operation channel: valid/ready handshake with the operation payload.
interface slist_req_if;
  import slist_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [OP_W-1:0]         operation;
  logic [POS_W-1:0]        position;
  logic signed [VAL_W-1:0] value;

  modport source (output valid, operation, position, value, input ready);
  modport sink   (input valid, operation, position, value, output ready);
endinterface

// ===== hdl/slist_rsp_if.sv =====
// Result channel: valid/ready handshake with the result payload.
interface slist_rsp_if;
  import slist_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [STAT_W-1:0]       status;
  logic signed [VAL_W-1:0] read_value;
  logic [IDX_W-1:0]        found_index;
  logic [CNT_W-1:0]        list_count;

  modport source (output valid, status, read_value, found_index, list_count, input ready);
  modport sink   (input valid, status, read_value, found_index, list_count, output ready);
endinterface

// ===== hdl/sequential_list_engine_core.sv =====
// Top level of the sequential list engine: controller, datapath and checks.
//
// The engine keeps an ordered list of up to CAPACITY signed 32-bit words in a
// single word RAM, together with its current length. Every beat on the req
// channel is one operation (get, locate, insert, delete, clear, or append if
// absent), and every operation produces exactly one beat on the rsp channel
// carrying a status code, the word read by get, the index found by locate and
// the list length after the operation. Operations are processed one at a
// time. Clear, failed range checks and the unused operation codes go from
// decode straight to the result; a successful get first captures the word
// read. Locate and append walk the list from the head and stop at a hit;
// an append that misses then adds its word at the tail if there is room.
// Insert moves every word from the tail down to the insert point up by
// one; delete moves the words after the removed one down by one. The
// walks are paced by the single read port of the word RAM, which visits
// one entry per cycle with its read data registered. The engine returns
// to idle at the edge that loads the result and can accept the next beat
// in the following cycle. The result sits in an output register, so the
// next operation is accepted while an earlier result still waits for
// rsp.ready; a result that finds that register still occupied waits
// before the engine returns to idle. Words of the RAM are never cleared:
// only positions below the current length are ever read, and those have
// always been written.
module sequential_list_engine_core #(
  parameter int CAPACITY = slist_pkg::CAPACITY_DEF
) (
  input  logic        clk,
  input  logic        rst,
  slist_req_if.sink   req,
  slist_rsp_if.source rsp
);
  import slist_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;
  logic     in_ready;

  assign req.ready = in_ready;

  // The controller owns the request handshake and sequences each operation.
  slist_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // The datapath holds the list, the walk pointer and the result register.
  slist_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .operation (req.operation),
    .position  (req.position),
    .value     (req.value),
    .rsp       (rsp)
  );

  // A word is never added to a list that already fills the store.
  a_no_put_when_full: assert property (@(posedge clk) disable iff (rst)
    cmd.put |-> !stat.full)
    else $error("word written while the store is full");

  // At most one change of the length per cycle.
  a_one_count_change: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.put, cmd.count_dec, cmd.count_clr}))
    else $error("conflicting length updates");

  // A new result is loaded only when the output register can take it.
  a_result_slot_free: assert property (@(posedge clk) disable iff (rst)
    cmd.result_load |-> stat.out_free)
    else $error("result overwrote a waiting beat");

  // An operation is accepted only when the previous one has been handed off.
  a_single_in_flight: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> !cmd.load && !req.ready)
    else $error("second operation accepted while one is in progress");
endmodule

// ===== hdl/slist_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
module slist_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== hdl/slist_dp.sv =====
// Datapath: operand registers, word RAM, walk pointer, length and result register.
module slist_dp #(
  parameter int CAPACITY = slist_pkg::CAPACITY_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  slist_pkg::dp_cmd_t             cmd,
  output slist_pkg::dp_stat_t            stat,
  input  logic [slist_pkg::OP_W-1:0]     operation,
  input  logic [slist_pkg::POS_W-1:0]    position,
  input  logic signed [slist_pkg::VAL_W-1:0] value,
  slist_rsp_if.source                    rsp
);
  import slist_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int MW = ((CW > POS_W) ? CW : POS_W) + 1;

  op_t              op_r;
  logic [POS_W-1:0] pos_r;
  logic [VAL_W-1:0] val_r;

  logic [CW-1:0] count;
  logic [CW-1:0] ptr;
  logic [CW-1:0] ptr_next;
  logic [CW-1:0] ptr_m1;
  logic          pend;
  logic          pend_next;
  logic [AW-1:0] pend_addr;
  logic [AW-1:0] pend_addr_next;

  status_t          res_status;
  logic [VAL_W-1:0] res_read;
  logic [AW-1:0]    res_idx;

  logic             out_valid;
  status_t          out_status;
  logic [VAL_W-1:0] out_read;
  logic [IDX_W-1:0] out_idx;
  logic [CNT_W-1:0] out_count;

  logic [MW-1:0] pos_ext;
  logic [MW-1:0] cnt_ext;
  logic [MW-1:0] ptr_ext;
  logic [MW-1:0] pos_m1_ext;
  logic [AW-1:0] pos_m1;
  logic [AW-1:0] put_addr;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] wr_addr;
  logic          wr_en;
  logic [VAL_W-1:0] wr_data;
  logic [VAL_W-1:0] rd_data;
  logic          hit;
  logic          walk_done;
  logic          shifting;

  assign pos_ext    = MW'(pos_r);
  assign cnt_ext    = MW'(count);
  assign ptr_ext    = MW'(ptr);
  assign pos_m1_ext = pos_ext - MW'(1);
  assign pos_m1     = pos_m1_ext[AW-1:0];
  assign ptr_m1     = ptr - CW'(1);

  assign hit      = pend && (rd_data == val_r);
  assign shifting = (op_r == OP_INSERT) || (op_r == OP_DELETE);

  // One entry per step: insert walks down from the tail, the others walk up.
  always_comb begin
    ptr_next       = ptr;
    pend_next      = 1'b0;
    pend_addr_next = pend_addr;
    case (op_r)
      OP_INSERT: begin
        if (ptr_ext >= pos_ext) begin
          ptr_next       = ptr_m1;
          pend_next      = 1'b1;
          pend_addr_next = ptr[AW-1:0];
        end
      end
      OP_DELETE: begin
        if (ptr < count) begin
          ptr_next       = ptr + CW'(1);
          pend_next      = 1'b1;
          pend_addr_next = ptr_m1[AW-1:0];
        end
      end
      default: begin
        if (ptr < count) begin
          ptr_next       = ptr + CW'(1);
          pend_next      = 1'b1;
          pend_addr_next = ptr[AW-1:0];
        end
      end
    endcase
  end

  always_comb begin
    case (op_r)
      OP_INSERT: walk_done = (ptr_ext < pos_ext) && !pend;
      OP_DELETE: walk_done = (ptr >= count) && !pend;
      default:   walk_done = hit || ((ptr >= count) && !pend);
    endcase
  end

  always_comb begin
    case (op_r)
      OP_GET:    rd_addr = pos_m1;
      OP_INSERT: rd_addr = ptr_m1[AW-1:0];
      default:   rd_addr = ptr[AW-1:0];
    endcase
  end

  assign put_addr = (op_r == OP_APPEND) ? count[AW-1:0] : pos_m1;
  assign wr_en    = cmd.put || (cmd.walk_step && pend && shifting);
  assign wr_addr  = cmd.put ? put_addr : pend_addr;
  assign wr_data  = cmd.put ? val_r : rd_data;

  slist_ram #(
    .WIDTH (VAL_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r       <= op_t'(operation);
      pos_r      <= position;
      val_r      <= value;
      res_status <= ST_OK;
      res_read   <= '0;
      res_idx    <= '0;
    end
    if (cmd.walk_init) begin
      pend <= 1'b0;
      case (op_r)
        OP_INSERT: ptr <= count;
        OP_DELETE: ptr <= pos_ext[CW-1:0];
        default:   ptr <= '0;
      endcase
    end else if (cmd.walk_step) begin
      ptr       <= ptr_next;
      pend      <= pend_next;
      pend_addr <= pend_addr_next;
    end
    if (cmd.walk_step && hit && (op_r == OP_LOCATE)) begin
      res_idx <= pend_addr;
    end
    if (cmd.get_capture) begin
      res_read <= rd_data;
    end
    if (cmd.set_status) begin
      res_status <= cmd.status_code;
    end
    if (cmd.result_load) begin
      out_status <= res_status;
      out_read   <= res_read;
      out_idx    <= IDX_W'(res_idx);
      out_count  <= CNT_W'(count);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.count_clr) begin
      count <= '0;
    end else if (cmd.put) begin
      count <= count + CW'(1);
    end else if (cmd.count_dec) begin
      count <= count - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.result_load) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.status      = out_status;
  assign rsp.read_value  = out_read;
  assign rsp.found_index = out_idx;
  assign rsp.list_count  = out_count;

  assign stat.op        = op_r;
  assign stat.get_ok    = (pos_r != '0) && (pos_ext <= cnt_ext);
  assign stat.ins_ok    = (pos_r != '0) && (pos_ext <= cnt_ext + MW'(1));
  assign stat.full      = (count == CW'(CAPACITY));
  assign stat.hit       = hit;
  assign stat.walk_done = walk_done;
  assign stat.out_free  = !out_valid || rsp.ready;
endmodule

// ===== hdl/slist_ctrl.sv =====
// Controller: sequences decode, RAM walk, final write and result hand-off.
module slist_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  slist_pkg::dp_stat_t stat,
  output slist_pkg::dp_cmd_t  cmd
);
  import slist_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE    = 6'b000001,
    S_DECODE  = 6'b000010,
    S_GET_CAP = 6'b000100,
    S_WALK    = 6'b001000,
    S_PUT     = 6'b010000,
    S_DONE    = 6'b100000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    in_ready   = 1'b0;
    state_next = state;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        state_next = S_DONE;
        case (stat.op)
          OP_GET: begin
            if (stat.get_ok) begin
              state_next = S_GET_CAP;
            end else begin
              cmd.set_status  = 1'b1;
              cmd.status_code = ST_BAD_POS;
            end
          end
          OP_LOCATE, OP_APPEND: begin
            cmd.walk_init = 1'b1;
            state_next    = S_WALK;
          end
          OP_INSERT: begin
            if (!stat.ins_ok) begin
              cmd.set_status  = 1'b1;
              cmd.status_code = ST_BAD_POS;
            end else if (stat.full) begin
              cmd.set_status  = 1'b1;
              cmd.status_code = ST_FULL;
            end else begin
              cmd.walk_init = 1'b1;
              state_next    = S_WALK;
            end
          end
          OP_DELETE: begin
            if (!stat.get_ok) begin
              cmd.set_status  = 1'b1;
              cmd.status_code = ST_BAD_POS;
            end else begin
              cmd.walk_init = 1'b1;
              state_next    = S_WALK;
            end
          end
          OP_CLEAR: begin
            cmd.count_clr = 1'b1;
          end
          default: begin
            state_next = S_DONE;
          end
        endcase
      end
      S_GET_CAP: begin
        cmd.get_capture = 1'b1;
        state_next      = S_DONE;
      end
      S_WALK: begin
        cmd.walk_step = 1'b1;
        if (stat.walk_done) begin
          state_next = S_DONE;
          case (stat.op)
            OP_LOCATE: begin
              if (!stat.hit) begin
                cmd.set_status  = 1'b1;
                cmd.status_code = ST_MATCH_FAIL;
              end
            end
            OP_APPEND: begin
              if (stat.hit) begin
                cmd.set_status  = 1'b1;
                cmd.status_code = ST_MATCH_FAIL;
              end else if (stat.full) begin
                cmd.set_status  = 1'b1;
                cmd.status_code = ST_FULL;
              end else begin
                state_next = S_PUT;
              end
            end
            OP_INSERT: begin
              state_next = S_PUT;
            end
            OP_DELETE: begin
              cmd.count_dec = 1'b1;
            end
            default: begin
              state_next = S_DONE;
            end
          endcase
        end
      end
      S_PUT: begin
        cmd.put    = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.result_load = 1'b1;
          state_next      = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end
endmodule
